FILE: rtl/frame_tag_crc16_hmac_sha256_core_assert.svh
// ----------------------------------------------------------------------------
// Frame tag core assertion macros
// Shorthand for clocked implication checks under the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_TAG_CRC16_HMAC_SHA256_CORE_ASSERT_SVH
`define FRAME_TAG_CRC16_HMAC_SHA256_CORE_ASSERT_SVH

// same-cycle implication
`define FTAG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame tag core: implication check failed");

// next-cycle implication
`define FTAG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame tag core: next-cycle check failed");

`endif

FILE: rtl/ftag_pkg.sv
// ----------------------------------------------------------------------------
// Frame tag package
// Shared types, codes, constants and the helper function of the frame tag core.
// ----------------------------------------------------------------------------
`default_nettype none

package ftag_pkg;

	localparam int TAG_MAX_DEF = 32;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;

	localparam logic [1:0] MODE_TAG    = 2'd0;
	localparam logic [1:0] MODE_VERIFY = 2'd1;
	localparam logic [1:0] MODE_RXTAG  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PROFILE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO  = 2'd2;

	localparam logic KIND_TAG     = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  IPAD     = 8'h36;
	localparam logic [7:0]  OPAD     = 8'h5c;

	typedef logic [0:7][31:0]  ftag_state_t;
	typedef logic [0:15][31:0] ftag_block_t;

	localparam ftag_state_t SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {PK_NONE, PK_CRC, PK_HMAC, PK_BAD} ftag_prof_t;
	typedef enum logic [2:0] {PS_DATA, PS_CTR, PS_80, PS_ZERO, PS_LEN} ftag_psel_t;

	typedef struct packed {
		logic       latch;
		logic       ipad_load;
		logic       push;
		ftag_psel_t push_sel;
		logic [2:0] push_idx;
		logic       crc_en;
		logic       len_cap;
		logic       sha_start;
		logic       opad_load;
		logic       outer_load;
		logic       dig_cap;
		logic       crc_cap;
		logic       close;
		logic       vsetup;
		logic       tag_check;
		logic       out_load;
		logic       out_kind;
		logic [4:0] out_idx;
		logic       out_end;
	} ftag_cmd_t;

	typedef struct packed {
		logic       frame_open;
		logic       verify_pending;
		logic       fill;
		logic       at56;
		logic       sha_done;
		logic       sha_busy;
		logic       out_free;
		logic [1:0] mode;
		logic       frame_end;
		logic [5:0] tag_length;
		ftag_prof_t prof;
		logic [5:0] prof_len;
		logic       vmatch;
	} ftag_sts_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ftag_sha.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One round per cycle over a 16-word schedule window; returns working vars.
// ----------------------------------------------------------------------------
`default_nettype none

module ftag_sha (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  ftag_pkg::ftag_block_t block,
	input  ftag_pkg::ftag_state_t init_v,
	output logic                 busy,
	output logic                 done,
	output ftag_pkg::ftag_state_t res
);
	import ftag_pkg::*;

	ftag_state_t v_q;
	ftag_block_t w_q;
	logic [5:0]  rnd_q;
	logic        busy_q, done_q;
	ftag_state_t v_nxt;
	logic [31:0] w_new, t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] k_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	always_comb begin
		w_new = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9]
			+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + k_const(rnd_q) + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		v_nxt = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 6'd1;
			if (rnd_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= init_v;
			w_q <= block;
		end else if (busy_q) begin
			v_q <= v_nxt;
			w_q <= {w_q[1:15], w_new};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = v_q;

endmodule

`default_nettype wire

FILE: rtl/ftag_dp.sv
// ----------------------------------------------------------------------------
// Frame tag datapath
// Config registers, item latch, CRC, block buffer, hash chain, tag and verdict
// state, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftag_dp #(
	parameter int TAG_MAX = ftag_pkg::TAG_MAX_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [ftag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [ftag_pkg::CFG_W-1:0]        cfg_data,
	input  wire  [1:0]                        mode,
	input  wire  [7:0]                        data_byte,
	input  wire                               frame_end,
	input  wire  [5:0]                        tag_length,
	input  ftag_pkg::ftag_cmd_t               cmd,
	output ftag_pkg::ftag_sts_t               sts,
	input  wire                               out_stall,
	output logic                              out_valid,
	output logic                              kind,
	output logic [7:0]                        tag_byte,
	output logic                              pass,
	output logic                              run_end
);
	import ftag_pkg::*;

	logic [5:0]   profile_q;
	logic [63:0]  key_up_q, key_lo_q;
	logic [1:0]   mode_q;
	logic [7:0]   byte_q;
	logic         end_q;
	logic [5:0]   tlen_q;
	logic [15:0]  crc_q;
	logic [511:0] buf_q;
	logic [63:0]  count_q, len_q;
	ftag_state_t  chain_q;
	logic [255:0] dig_q;
	logic [31:0]  round_q;
	logic [5:0]   ti_q, pend_q;
	logic         mm_q, fo_q, vp_q;
	logic         ov_q, kind_q, pass_q, rend_q;
	logic [7:0]   tb_q;

	logic [127:0] key;
	logic [511:0] ipad_blk, opad_blk, outer_blk;
	logic [7:0]   pbyte, exp_byte, out_tb;
	ftag_prof_t   prof;
	logic [5:0]   prof_len;
	logic         sha_busy, sha_done;
	ftag_state_t  sha_res;
	logic         out_free;

	assign key       = {key_up_q, key_lo_q};
	assign ipad_blk  = {key ^ {16{IPAD}}, {48{IPAD}}};
	assign opad_blk  = {key ^ {16{OPAD}}, {48{OPAD}}};
	assign outer_blk = {dig_q, 8'h80, 232'd0, 16'h0300};
	assign exp_byte  = dig_q[{~ti_q[4:0], 3'b000} +: 8];
	assign out_tb    = dig_q[{~cmd.out_idx, 3'b000} +: 8];
	assign out_free  = !ov_q || !out_stall;

	always_comb begin
		prof     = PK_BAD;
		prof_len = '0;
		if (profile_q == 6'd0) begin
			prof = PK_NONE;
		end else if (profile_q == 6'd2) begin
			prof     = PK_CRC;
			prof_len = 6'd2;
		end else if (profile_q >= 6'd4 && int'(profile_q) <= TAG_MAX) begin
			prof     = PK_HMAC;
			prof_len = profile_q;
		end
	end

	always_comb begin
		case (cmd.push_sel)
			PS_DATA: pbyte = byte_q;
			PS_CTR:  pbyte = round_q[{~cmd.push_idx[1:0], 3'b000} +: 8];
			PS_80:   pbyte = 8'h80;
			PS_ZERO: pbyte = 8'h00;
			PS_LEN:  pbyte = len_q[{~cmd.push_idx, 3'b000} +: 8];
			default: pbyte = 8'h00;
		endcase
	end

	ftag_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sha_start),
		.block  (ftag_block_t'(buf_q)),
		.init_v (chain_q),
		.busy   (sha_busy),
		.done   (sha_done),
		.res    (sha_res)
	);

	// control and config state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_q <= '0;
			key_up_q  <= '0;
			key_lo_q  <= '0;
			crc_q     <= '0;
			count_q   <= '0;
			round_q   <= '0;
			ti_q      <= '0;
			pend_q    <= '0;
			mm_q      <= 1'b0;
			fo_q      <= 1'b0;
			vp_q      <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROFILE: profile_q <= cfg_data[5:0];
					REG_KEY_UP:  key_up_q  <= cfg_data;
					REG_KEY_LO:  key_lo_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.ipad_load) begin
				crc_q   <= '0;
				count_q <= 64'd64;
				fo_q    <= 1'b1;
				vp_q    <= 1'b0;
			end
			if (cmd.crc_en)
				crc_q <= crc16_byte(crc_q, byte_q);
			if (cmd.push)
				count_q <= count_q + 64'd1;
			if (cmd.close)
				fo_q <= 1'b0;
			if (cmd.dig_cap)
				round_q <= round_q + 32'd1;
			if (cmd.vsetup) begin
				mm_q   <= !sts.vmatch;
				ti_q   <= '0;
				pend_q <= tlen_q;
				vp_q   <= (tlen_q != 6'd0);
			end
			if (cmd.tag_check) begin
				if (ti_q >= pend_q)
					mm_q <= 1'b1;
				else if (!mm_q && exp_byte != byte_q)
					mm_q <= 1'b1;
				if (ti_q != 6'd63)
					ti_q <= ti_q + 6'd1;
				if (end_q)
					vp_q <= 1'b0;
			end
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			byte_q <= data_byte;
			end_q  <= frame_end;
			tlen_q <= tag_length;
		end
		if (cmd.ipad_load)
			buf_q <= ipad_blk;
		else if (cmd.opad_load)
			buf_q <= opad_blk;
		else if (cmd.outer_load)
			buf_q <= outer_blk;
		else if (cmd.push)
			buf_q <= {buf_q[503:0], pbyte};
		if (cmd.len_cap)
			len_q <= {count_q[60:0], 3'b000};
		if (cmd.ipad_load || cmd.opad_load) begin
			chain_q <= SHA_IV;
		end else if (sha_done) begin
			for (int i = 0; i < 8; i++)
				chain_q[i] <= chain_q[i] + sha_res[i];
		end
		if (cmd.opad_load || cmd.dig_cap)
			dig_q <= chain_q;
		else if (cmd.crc_cap)
			dig_q <= {crc_q[7:0], crc_q[15:8], 240'd0};
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			tb_q   <= (cmd.out_kind == KIND_TAG) ? out_tb : 8'h00;
			pass_q <= (cmd.out_kind == KIND_VERDICT) && !mm_q && (ti_q == pend_q);
			rend_q <= cmd.out_end;
		end
	end

	always_comb begin
		sts.frame_open     = fo_q;
		sts.verify_pending = vp_q;
		sts.fill           = (count_q[5:0] == 6'd63);
		sts.at56           = (count_q[5:0] == 6'd56);
		sts.sha_done       = sha_done;
		sts.sha_busy       = sha_busy;
		sts.out_free       = out_free;
		sts.mode           = mode_q;
		sts.frame_end      = end_q;
		sts.tag_length     = tlen_q;
		sts.prof           = prof;
		sts.prof_len       = prof_len;
		sts.vmatch         = (prof != PK_BAD) && (prof_len == tlen_q);
	end

	assign out_valid = ov_q;
	assign kind      = kind_q;
	assign tag_byte  = tb_q;
	assign pass      = pass_q;
	assign run_end   = rend_q;

endmodule

`default_nettype wire

FILE: rtl/ftag_ctrl.sv
// ----------------------------------------------------------------------------
// Frame tag controller
// Sequences item intake, key blocks, padding, compressions and result output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_tag_crc16_hmac_sha256_core_assert.svh"

module ftag_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  ftag_pkg::ftag_sts_t sts,
	output ftag_pkg::ftag_cmd_t cmd
);
	import ftag_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_DATA, S_END, S_PAD, S_OPAD, S_OUTER, S_FIN,
		S_EMIT, S_VERDICT, S_HSTART, S_HWAIT
	} state_t;

	typedef enum logic [1:0] {PH_CTR, PH_80, PH_ZERO, PH_LEN} phase_t;

	state_t     state_q, state_d, ret_q, ret_d;
	phase_t     ph_q, ph_d;
	logic [2:0] pidx_q, pidx_d;
	logic [4:0] emit_q, emit_d;

	always_comb begin
		cmd      = '0;
		cmd.push_sel = PS_DATA;
		state_d  = state_q;
		ret_d    = ret_q;
		ph_d     = ph_q;
		pidx_d   = pidx_q;
		emit_d   = emit_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.mode == MODE_TAG || sts.mode == MODE_VERIFY) begin
					if (!sts.frame_open) begin
						cmd.ipad_load = 1'b1;
						state_d       = S_HSTART;
						ret_d         = S_DATA;
					end else begin
						state_d = S_DATA;
					end
				end else if (sts.mode == MODE_RXTAG && sts.verify_pending && !sts.frame_open) begin
					cmd.tag_check = 1'b1;
					state_d       = sts.frame_end ? S_VERDICT : S_IDLE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DATA: begin
				cmd.crc_en   = 1'b1;
				cmd.push     = 1'b1;
				cmd.push_sel = PS_DATA;
				if (sts.fill) begin
					state_d = S_HSTART;
					ret_d   = S_END;
				end else begin
					state_d = S_END;
				end
			end
			S_END: begin
				state_d = S_IDLE;
				ph_d    = PH_CTR;
				pidx_d  = '0;
				emit_d  = '0;
				if (sts.frame_end) begin
					cmd.close = 1'b1;
					if (sts.mode == MODE_TAG) begin
						case (sts.prof)
							PK_CRC: begin
								cmd.crc_cap = 1'b1;
								state_d     = S_EMIT;
							end
							PK_HMAC: state_d = S_PAD;
							default: state_d = S_IDLE;
						endcase
					end else begin
						cmd.vsetup = 1'b1;
						if (sts.vmatch && sts.prof == PK_CRC)
							cmd.crc_cap = 1'b1;
						if (sts.vmatch && sts.prof == PK_HMAC)
							state_d = S_PAD;
						else if (sts.tag_length == 6'd0)
							state_d = S_VERDICT;
					end
				end
			end
			S_PAD: begin
				cmd.push_idx = pidx_q;
				case (ph_q)
					PH_CTR: begin
						cmd.push     = 1'b1;
						cmd.push_sel = PS_CTR;
						if (pidx_q == 3'd3) begin
							ph_d   = PH_80;
							pidx_d = '0;
						end else begin
							pidx_d = pidx_q + 3'd1;
						end
					end
					PH_80: begin
						cmd.push     = 1'b1;
						cmd.push_sel = PS_80;
						cmd.len_cap  = 1'b1;
						ph_d         = PH_ZERO;
					end
					PH_ZERO: begin
						if (sts.at56) begin
							ph_d   = PH_LEN;
							pidx_d = '0;
						end else begin
							cmd.push     = 1'b1;
							cmd.push_sel = PS_ZERO;
						end
					end
					PH_LEN: begin
						cmd.push     = 1'b1;
						cmd.push_sel = PS_LEN;
						pidx_d       = pidx_q + 3'd1;
					end
					default: ph_d = PH_CTR;
				endcase
				if (cmd.push && sts.fill) begin
					state_d = S_HSTART;
					ret_d   = (ph_q == PH_LEN && pidx_q == 3'd7) ? S_OPAD : S_PAD;
				end
			end
			S_OPAD: begin
				cmd.opad_load = 1'b1;
				state_d       = S_HSTART;
				ret_d         = S_OUTER;
			end
			S_OUTER: begin
				cmd.outer_load = 1'b1;
				state_d        = S_HSTART;
				ret_d          = S_FIN;
			end
			S_FIN: begin
				cmd.dig_cap = 1'b1;
				emit_d      = '0;
				state_d     = (sts.mode == MODE_TAG) ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				cmd.out_kind = KIND_TAG;
				cmd.out_idx  = emit_q;
				cmd.out_end  = ({1'b0, emit_q} == sts.prof_len - 6'd1);
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					emit_d       = emit_q + 5'd1;
					if (cmd.out_end)
						state_d = S_IDLE;
				end
			end
			S_VERDICT: begin
				cmd.out_kind = KIND_VERDICT;
				cmd.out_end  = 1'b1;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_HSTART: begin
				cmd.sha_start = 1'b1;
				state_d       = S_HWAIT;
			end
			S_HWAIT: begin
				if (sts.sha_done)
					state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			ph_q    <= PH_CTR;
			pidx_q  <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			ph_q    <= ph_d;
			pidx_q  <= pidx_d;
			emit_q  <= emit_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	`FTAG_ASSERT_IMP(a_out_slot_free, cmd.out_load, sts.out_free)
	`FTAG_ASSERT_IMP(a_sha_start_idle, cmd.sha_start, !sts.sha_busy)
	`FTAG_ASSERT_NEXT(a_full_block_hashed, cmd.push && sts.fill, state_q == S_HSTART)

endmodule

`default_nettype wire

FILE: rtl/frame_tag_crc16_hmac_sha256_core.sv
// A frame byte passes the decode, data and end states; a byte that opens a frame
// first compresses the key block, and a byte that fills a 64-byte block compresses it.
// The HMAC finish after the last byte pads one byte per cycle, save during
// compressions, plus three to four compressions on the single round engine.
// Tag bytes then leave one per cycle unless out_stall holds them back.
// Asynchronous active-low reset clears config, counters, flags and the output valid.
// ----------------------------------------------------------------------------
// Frame tag core
// CRC-16/ARC or truncated HMAC-SHA256 tag generation and verification.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_tag_crc16_hmac_sha256_core #(
	parameter int TAG_MAX = ftag_pkg::TAG_MAX_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [ftag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [ftag_pkg::CFG_W-1:0]     cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     mode,
	input  wire  [7:0]                     data_byte,
	input  wire                            frame_end,
	input  wire  [5:0]                     tag_length,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           kind,
	output logic [7:0]                     tag_byte,
	output logic                           pass,
	output logic                           run_end
);
	import ftag_pkg::*;

	ftag_cmd_t cmd;
	ftag_sts_t sts;

	ftag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftag_dp #(
		.TAG_MAX (TAG_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.tag_length (tag_length),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.kind       (kind),
		.tag_byte   (tag_byte),
		.pass       (pass),
		.run_end    (run_end)
	);

endmodule

`default_nettype wire
